>>> design/led_xf_pkg.sv
// ----------------------------------------------------------------------------
// led_xf_pkg
// Shared constants and types for the LED color crossfade block.
// ----------------------------------------------------------------------------
package led_xf_pkg;

  localparam int LED_COUNT   = 10;
  localparam int LED_W       = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int WEIGHT_BITS = 16;
  localparam int DIV_CNT_W   = $clog2(WEIGHT_BITS);
  localparam int PROD_W      = WEIGHT_BITS + 1 + 9;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_SET  = 2'd1;
  localparam logic [1:0] CMD_FILL = 2'd2;

  localparam logic CFG_SLOWDOWN = 1'b0;
  localparam logic CFG_SMOOTH   = 1'b1;

  localparam logic [7:0] SLOWDOWN_RESET = 8'd100;

  localparam logic [1:0] CH_RED  = 2'd0;
  localparam logic [1:0] CH_BLUE = 2'd2;

  typedef logic [23:0] color_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_MIX,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  function automatic logic [7:0] color_byte(input color_t c, input logic [1:0] ch);
    logic [7:0] b;
    case (ch)
      2'd0:    b = c[23:16];
      2'd1:    b = c[15:8];
      default: b = c[7:0];
    endcase
    return b;
  endfunction

endpackage

>>> design/led_color_crossfade.sv
// ----------------------------------------------------------------------------
// led_color_crossfade
// Per-LED linear color fade with a shared divider and blend multiplier.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries a command and a color. A tick
// walks every LED in order and produces one output transfer per LED on the
// out_valid/out_stall channel, the final one flagged by last_led. Set and
// fill commands update the color images and produce no output.
// Per LED a tick runs a check state; unless the fade is done it then runs
// the bit-serial restoring divider that forms the 16-bit weight, the blend
// multiplier (one channel at a time) and an update state; last it loads
// the output register. in_stall stays high until the last result is
// loaded into the output register.
// When the receiver stalls, the current result is held and the walk pauses.
// Configuration writes (cfg_valid/cfg_ready) are always accepted and must
// only be issued while the block is idle. Reset clears all color images
// and step counts, sets slowdown_steps to 100 and enables smoothing.
// ----------------------------------------------------------------------------
module led_color_crossfade
  import led_xf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  input  logic [5:0] led_index,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] led_number,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  output logic       last_led,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  color_t     start_color   [LED_COUNT];
  color_t     current_color [LED_COUNT];
  color_t     target_color  [LED_COUNT];
  logic [7:0] fade_step     [LED_COUNT];

  logic [7:0] slowdown_steps;
  logic       smooth_enable;

  state_t     state, state_next;
  logic [LED_W-1:0]       led;
  logic [DIV_CNT_W-1:0]   div_cnt;
  logic [7:0]             rem;
  logic [WEIGHT_BITS-1:0] weight;
  logic [1:0]             chan;
  color_t                 result;

  logic                   in_xfer;
  logic                   out_free;
  logic                   led_last;
  logic                   fade_done;
  logic [8:0]             rem_shift;
  logic                   rem_ge;
  logic [7:0]             mix_a, mix_b;
  logic signed [8:0]      diff;
  logic signed [PROD_W-1:0] prod;
  logic [7:0]             mix_byte;
  color_t                 in_color;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign led_last  = (led == LED_W'(LED_COUNT - 1));
  assign fade_done = (fade_step[led] >= slowdown_steps);
  assign in_color  = {red_in, green_in, blue_in};

  // restoring divider step
  assign rem_shift = {rem, 1'b0};
  assign rem_ge    = (rem_shift >= {1'b0, slowdown_steps});

  // blend: a + floor(w * (b - a) / 2^WEIGHT_BITS)
  assign mix_a    = color_byte(start_color[led], chan);
  assign mix_b    = color_byte(target_color[led], chan);
  assign diff     = $signed({1'b0, mix_b}) - $signed({1'b0, mix_a});
  assign prod     = PROD_W'($signed({1'b0, weight})) * PROD_W'(diff);
  assign mix_byte = mix_a + prod[WEIGHT_BITS+7:WEIGHT_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer && command == CMD_TICK) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = fade_done ? ST_EMIT : ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt == DIV_CNT_W'(WEIGHT_BITS - 1)) begin
          state_next = ST_MIX;
        end
      end
      ST_MIX: begin
        if (chan == CH_BLUE) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = led_last ? ST_IDLE : ST_CHECK;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slowdown_steps <= SLOWDOWN_RESET;
      smooth_enable  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SLOWDOWN: slowdown_steps <= cfg_data;
        CFG_SMOOTH:   smooth_enable  <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  // color images and step counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        start_color[i]   <= '0;
        current_color[i] <= '0;
        target_color[i]  <= '0;
        fade_step[i]     <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xfer && command == CMD_SET &&
              {1'b0, led_index} < 7'(LED_COUNT)) begin
            target_color[led_index[LED_W-1:0]] <= in_color;
            start_color[led_index[LED_W-1:0]]  <= current_color[led_index[LED_W-1:0]];
            fade_step[led_index[LED_W-1:0]]    <= '0;
          end else if (in_xfer && command == CMD_FILL) begin
            for (int i = 0; i < LED_COUNT; i++) begin
              start_color[i]   <= in_color;
              current_color[i] <= in_color;
              target_color[i]  <= in_color;
            end
          end
        end
        ST_CHECK: begin
          if (fade_done) begin
            start_color[led]   <= target_color[led];
            current_color[led] <= target_color[led];
          end
        end
        ST_UPDATE: begin
          current_color[led] <= result;
          fade_step[led]     <= fade_step[led] + 8'd1;
        end
        default: ;
      endcase
    end
  end

  // walk counter, divider and blend registers
  always_ff @(posedge clk) begin
    if (rst) begin
      led <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          led <= '0;
        end
        ST_CHECK: begin
          rem     <= fade_step[led];
          weight  <= '0;
          div_cnt <= '0;
          chan    <= CH_RED;
          result  <= target_color[led];
        end
        ST_DIV: begin
          rem     <= rem_ge ? 8'(rem_shift - {1'b0, slowdown_steps}) : rem_shift[7:0];
          weight  <= {weight[WEIGHT_BITS-2:0], rem_ge};
          div_cnt <= div_cnt + DIV_CNT_W'(1);
        end
        ST_MIX: begin
          result[23 - 8 * chan -: 8] <= mix_byte;
          chan <= chan + 2'd1;
        end
        ST_EMIT: begin
          if (out_free && !led_last) begin
            led <= led + LED_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      led_number <= 6'(led);
      last_led   <= led_last;
      if (smooth_enable) begin
        {red_out, green_out, blue_out} <= result;
      end else begin
        {red_out, green_out, blue_out} <= target_color[led];
      end
    end
  end

endmodule
